FILE: rtl/baro_temp_pressure_compensation_top_defines.svh
// Assertion macros used by the port-level checker of the compensation block.
`ifndef BARO_TEMP_PRESSURE_COMPENSATION_TOP_DEFINES_SVH
`define BARO_TEMP_PRESSURE_COMPENSATION_TOP_DEFINES_SVH

// Clocked assertion that is switched off while reset is asserted.
`define BTPC_ASSERT_RST(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define BTPC_ASSERT_CLK(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/btpc_pkg.sv
// Types, constants and helpers of the pressure and temperature compensation block.
package btpc_pkg;

  localparam int DIV_W      = 32;
  localparam int NUM_REGS   = 8;
  localparam int ADDR_W     = 5;
  localparam int PSHIFT_MAX = 8;

  localparam logic [31:0] MG_CONST  = 32'd3038;
  localparam logic [31:0] MH_CONST  = 32'hFFFFE343;
  localparam logic [31:0] MI_CONST  = 32'd3791;
  localparam logic [31:0] B6_OFFSET = 32'd4000;
  localparam logic [31:0] B7_SCALE  = 32'd50000;
  localparam logic [31:0] B7_LIMIT  = 32'h80000000;
  localparam logic [31:0] B4_OFFSET = 32'd32768;

  // Register indexes.
  localparam logic [2:0] REG_AC1   = 3'd0;
  localparam logic [2:0] REG_AC2   = 3'd1;
  localparam logic [2:0] REG_AC3   = 3'd2;
  localparam logic [2:0] REG_AC4   = 3'd3;
  localparam logic [2:0] REG_AC5   = 3'd4;
  localparam logic [2:0] REG_AC6   = 3'd5;
  localparam logic [2:0] REG_B1_B2 = 3'd6;
  localparam logic [2:0] REG_MC_MD = 3'd7;

  // Pipeline stage numbers.
  localparam int ST_IN     = 0;
  localparam int ST_MUL_T  = 1;
  localparam int ST_DEN    = 2;
  localparam int ST_TSETUP = 3;
  localparam int ST_TDIV0  = 4;
  localparam int ST_TDIVN  = ST_TDIV0 + DIV_W - 1;
  localparam int ST_B5     = ST_TDIVN + 1;
  localparam int ST_B6     = ST_B5 + 1;
  localparam int ST_MUL_B6 = ST_B6 + 1;
  localparam int ST_SQ     = ST_MUL_B6 + 1;
  localparam int ST_MUL_SQ = ST_SQ + 1;
  localparam int ST_B3     = ST_MUL_SQ + 1;
  localparam int ST_MUL_B4 = ST_B3 + 1;
  localparam int ST_B4     = ST_MUL_B4 + 1;
  localparam int ST_MUL_B7 = ST_B4 + 1;
  localparam int ST_PSETUP = ST_MUL_B7 + 1;
  localparam int ST_PDIV0  = ST_PSETUP + 1;
  localparam int ST_PDIVN  = ST_PDIV0 + DIV_W - 1;
  localparam int ST_P      = ST_PDIVN + 1;
  localparam int ST_MUL_P  = ST_P + 1;
  localparam int ST_MUL_PP = ST_MUL_P + 1;
  localparam int ST_MUL_MG = ST_MUL_PP + 1;
  localparam int ST_SUM    = ST_MUL_MG + 1;
  localparam int NSTG      = ST_SUM + 1;

  typedef struct packed {
    logic [15:0] raw_temperature;
    logic [23:0] raw_pressure;
    logic [1:0]  oversampling_mode;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] temperature_tenths;
    logic signed [31:0] pressure_pa;
    logic               divide_error;
  } out_item_t;

  // Working set of one item as it moves down the pipeline.
  typedef struct packed {
    logic [15:0] ut;
    logic [23:0] up;
    logic [1:0]  mode;
    logic [31:0] x1;
    logic [31:0] b6;
    logic [31:0] t1;
    logic [31:0] t2;
    logic [31:0] t3;
    logic [31:0] rem;
    logic [31:0] quot;
    logic [31:0] dvs;
    logic        neg;
    logic        post;
    logic        err;
    logic [15:0] temp;
    logic [31:0] pres;
  } ctx_t;

  function automatic logic [31:0] asr32(logic [31:0] v, int n);
    return 32'($signed(v) >>> n);
  endfunction

  function automatic logic [31:0] sext16(logic [15:0] v);
    return {{16{v[15]}}, v};
  endfunction

endpackage

FILE: rtl/baro_temp_pressure_compensation_top.sv
// Top level of the barometric pressure and temperature compensation pipeline.
// The pipeline has 83 stages. Throughput: one item per cycle while the output is not
// stalled; two 32-stage restoring dividers, one quotient bit per stage, set the depth.
// A stall at the output freezes every stage at once.
// Reset clears the stage valid bits and all calibration registers to zero.
module baro_temp_pressure_compensation_top (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  btpc_pkg::in_item_t    in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output btpc_pkg::out_item_t   out_data_o,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [btpc_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);
  import btpc_pkg::*;

  logic [15:0] ac1_q, ac2_q, ac3_q, ac4_q, ac5_q, ac6_q;
  logic [31:0] b1b2_q, mcmd_q;
  logic [31:0] ac1_s, ac2_s, ac3_s, ac4_u, ac5_u, ac6_u, b1_s, b2_s, mc_s, md_s;
  logic [2:0]  reg_idx;
  logic        wr_en;

  ctx_t        pipe_q [NSTG];
  ctx_t        nxt    [1:NSTG-1];
  logic [NSTG-1:0] valid_q;
  logic        adv;
  ctx_t        in_ctx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ac1_q  <= '0;
      ac2_q  <= '0;
      ac3_q  <= '0;
      ac4_q  <= '0;
      ac5_q  <= '0;
      ac6_q  <= '0;
      b1b2_q <= '0;
      mcmd_q <= '0;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_AC1:   ac1_q  <= pwdata[15:0];
        REG_AC2:   ac2_q  <= pwdata[15:0];
        REG_AC3:   ac3_q  <= pwdata[15:0];
        REG_AC4:   ac4_q  <= pwdata[15:0];
        REG_AC5:   ac5_q  <= pwdata[15:0];
        REG_AC6:   ac6_q  <= pwdata[15:0];
        REG_B1_B2: b1b2_q <= pwdata;
        REG_MC_MD: mcmd_q <= pwdata;
        default:   ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_AC1:   prdata = {16'd0, ac1_q};
      REG_AC2:   prdata = {16'd0, ac2_q};
      REG_AC3:   prdata = {16'd0, ac3_q};
      REG_AC4:   prdata = {16'd0, ac4_q};
      REG_AC5:   prdata = {16'd0, ac5_q};
      REG_AC6:   prdata = {16'd0, ac6_q};
      REG_B1_B2: prdata = b1b2_q;
      REG_MC_MD: prdata = mcmd_q;
      default:   prdata = '0;
    endcase
  end

  assign ac1_s = sext16(ac1_q);
  assign ac2_s = sext16(ac2_q);
  assign ac3_s = sext16(ac3_q);
  assign ac4_u = {16'd0, ac4_q};
  assign ac5_u = {16'd0, ac5_q};
  assign ac6_u = {16'd0, ac6_q};
  assign b1_s  = sext16(b1b2_q[31:16]);
  assign b2_s  = sext16(b1b2_q[15:0]);
  assign mc_s  = sext16(mcmd_q[31:16]);
  assign md_s  = sext16(mcmd_q[15:0]);

  // One restoring division step: shift in the next dividend bit, subtract if it fits.
  function automatic ctx_t div_step(ctx_t c);
    ctx_t        r;
    logic [32:0] sh;
    logic [32:0] diff;
    r    = c;
    sh   = {c.rem, c.quot[31]};
    diff = sh - {1'b0, c.dvs};
    if (!diff[32]) begin
      r.rem  = diff[31:0];
      r.quot = {c.quot[30:0], 1'b1};
    end else begin
      r.rem  = sh[31:0];
      r.quot = {c.quot[30:0], 1'b0};
    end
    return r;
  endfunction

  function automatic ctx_t stage_step(int k, ctx_t c);
    ctx_t        r;
    logic [31:0] s;
    logic [31:0] b4;
    r = c;
    case (k) inside
      ST_MUL_T: begin
        r.t1 = ({16'd0, c.ut} - ac6_u) * ac5_u;
      end
      ST_DEN: begin
        s    = asr32(c.t1, 15);
        r.x1 = s;
        r.t2 = s + md_s;
        r.t3 = mc_s << 11;
        r.err = ((s + md_s) == 32'd0);
      end
      ST_TSETUP: begin
        r.neg  = c.t3[31] ^ c.t2[31];
        r.quot = c.t3[31] ? (32'd0 - c.t3) : c.t3;
        r.dvs  = c.t2[31] ? (32'd0 - c.t2) : c.t2;
        r.rem  = '0;
      end
      [ST_TDIV0:ST_TDIVN]: begin
        r = div_step(c);
      end
      ST_B5: begin
        r.t1 = c.x1 + (c.neg ? (32'd0 - c.quot) : c.quot);
      end
      ST_B6: begin
        s      = asr32(c.t1 + 32'd8, 4);
        r.temp = s[15:0];
        r.b6   = c.t1 - B6_OFFSET;
      end
      ST_MUL_B6: begin
        r.t1 = c.b6 * c.b6;
        r.t2 = ac2_s * c.b6;
        r.x1 = ac3_s * c.b6;
      end
      ST_SQ: begin
        r.t1 = asr32(c.t1, 12);
        r.t2 = asr32(c.t2, 11);
        r.x1 = asr32(c.x1, 13);
      end
      ST_MUL_SQ: begin
        r.t1 = c.t1 * b2_s;
        r.t3 = b1_s * c.t1;
      end
      ST_B3: begin
        s    = ((ac1_s << 2) + asr32(c.t1, 11) + c.t2) << c.mode;
        r.t2 = asr32(s + 32'd2, 2);
        r.t1 = asr32(c.x1 + asr32(c.t3, 16) + 32'd2, 2);
      end
      ST_MUL_B4: begin
        r.t1 = ac4_u * (c.t1 + B4_OFFSET);
      end
      ST_B4: begin
        b4    = c.t1 >> 15;
        r.dvs = b4;
        r.err = c.err | (b4 == 32'd0);
        r.t2  = {8'd0, c.up} - c.t2;
      end
      ST_MUL_B7: begin
        r.t2 = c.t2 * (B7_SCALE >> c.mode);
      end
      ST_PSETUP: begin
        r.rem = '0;
        if (c.t2 < B7_LIMIT) begin
          r.quot = c.t2 << 1;
          r.post = 1'b0;
        end else begin
          r.quot = c.t2;
          r.post = 1'b1;
        end
      end
      [ST_PDIV0:ST_PDIVN]: begin
        r = div_step(c);
      end
      ST_P: begin
        r.pres = c.post ? (c.quot << 1) : c.quot;
      end
      ST_MUL_P: begin
        r.t1 = asr32(c.pres, 8);
        r.t2 = c.pres * MH_CONST;
      end
      ST_MUL_PP: begin
        r.t1 = c.t1 * c.t1;
        r.t2 = asr32(c.t2, 16);
      end
      ST_MUL_MG: begin
        r.t1 = c.t1 * MG_CONST;
      end
      ST_SUM: begin
        r.pres = c.pres + asr32(asr32(c.t1, 16) + c.t2 + MI_CONST, 4);
      end
      default: ;
    endcase
    return r;
  endfunction

  always_comb begin
    in_ctx      = '0;
    in_ctx.ut   = in_data_i.raw_temperature;
    in_ctx.mode = in_data_i.oversampling_mode;
    in_ctx.up   = in_data_i.raw_pressure >>
                  (4'(PSHIFT_MAX) - {2'b00, in_data_i.oversampling_mode});
  end

  always_comb begin
    for (int k = 1; k < NSTG; k++) begin
      nxt[k] = stage_step(k, pipe_q[k-1]);
    end
  end

  // The whole pipeline moves together whenever the last stage is free or being taken.
  assign adv        = !valid_q[NSTG-1] || out_ready_i;
  assign in_ready_o = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (adv) begin
      valid_q <= {valid_q[NSTG-2:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      pipe_q[ST_IN] <= in_ctx;
      for (int k = 1; k < NSTG; k++) begin
        pipe_q[k] <= nxt[k];
      end
    end
  end

  assign out_valid_o = valid_q[NSTG-1];

  always_comb begin
    if (pipe_q[NSTG-1].err) begin
      out_data_o.temperature_tenths = '0;
      out_data_o.pressure_pa        = '0;
      out_data_o.divide_error       = 1'b1;
    end else begin
      out_data_o.temperature_tenths = pipe_q[NSTG-1].temp;
      out_data_o.pressure_pa        = pipe_q[NSTG-1].pres;
      out_data_o.divide_error       = 1'b0;
    end
  end

endmodule

FILE: rtl/btpc_checker.sv
// Port-level checker of the compensation block and its bind statement.
`include "baro_temp_pressure_compensation_top_defines.svh"

module btpc_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_ready_o,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input btpc_pkg::out_item_t out_data_o,
  input logic                pready
);
  import btpc_pkg::*;

  // A result that is held back stays offered.
  `BTPC_ASSERT_RST(a_out_hold, clk_i, rst_ni,
    out_valid_o && !out_ready_i |=> out_valid_o, "output valid dropped during stall")
  // Its payload does not move while it waits.
  `BTPC_ASSERT_RST(a_out_stable, clk_i, rst_ni,
    out_valid_o && !out_ready_i |=> $stable(out_data_o), "output payload changed during stall")
  // A divide error forces both result fields to zero.
  `BTPC_ASSERT_RST(a_err_zero, clk_i, rst_ni,
    out_valid_o && out_data_o.divide_error |-> out_data_o.temperature_tenths == 16'sd0 &&
    out_data_o.pressure_pa == 32'sd0, "error result not zeroed")
  // The input side is open exactly when the last stage can move.
  `BTPC_ASSERT_RST(a_ready_link, clk_i, rst_ni,
    in_ready_o == (!out_valid_o || out_ready_i), "input ready not tied to output flow")
  // The register port never inserts wait states.
  `BTPC_ASSERT_CLK(a_pready, clk_i, pready, "pready low")

endmodule

bind baro_temp_pressure_compensation_top btpc_checker u_btpc_checker (.*);

FILE: tb/btpc_checker.sv
// Scoreboard for the compensation block: predicts each result and compares it.
`timescale 1ns / 100ps
module btpc_scoreboard (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_ready_i,
  input  btpc_pkg::in_item_t  in_data_i,
  input  logic                out_valid_i,
  input  logic                out_ready_i,
  input  btpc_pkg::out_item_t out_data_i,
  input  logic                psel_i,
  input  logic                penable_i,
  input  logic                pwrite_i,
  input  logic [4:0]          paddr_i,
  input  logic [31:0]         pwdata_i,
  input  logic                pready_i,
  output int                  fail_count_o,
  output int                  pending_o,
  output int                  result_count_o,
  output int                  div_error_count_o
);
  import btpc_pkg::*;

  logic [31:0] cal_regs [NUM_REGS];
  out_item_t   expected_q [$];

  function automatic logic [31:0] shr_s(logic [31:0] v, int n);
    return 32'($signed(v) >>> n);
  endfunction

  function automatic logic [31:0] ext16(logic [15:0] v);
    return {{16{v[15]}}, v};
  endfunction

  function automatic logic [31:0] div_trunc(logic [31:0] a, logic [31:0] b);
    logic [31:0] ma, mb, q;
    ma = a[31] ? -a : a;
    mb = b[31] ? -b : b;
    q = ma / mb;
    return (a[31] != b[31]) ? -q : q;
  endfunction

  function automatic out_item_t compensate(in_item_t it);
    out_item_t r;
    logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
    logic [31:0] x1, x2, x3, den, b5, b6, b3, b4, b7, up, p, sq, tmp;
    int m;
    ac1 = ext16(cal_regs[REG_AC1][15:0]);
    ac2 = ext16(cal_regs[REG_AC2][15:0]);
    ac3 = ext16(cal_regs[REG_AC3][15:0]);
    ac4 = {16'd0, cal_regs[REG_AC4][15:0]};
    ac5 = {16'd0, cal_regs[REG_AC5][15:0]};
    ac6 = {16'd0, cal_regs[REG_AC6][15:0]};
    b1 = ext16(cal_regs[REG_B1_B2][31:16]);
    b2 = ext16(cal_regs[REG_B1_B2][15:0]);
    mc = ext16(cal_regs[REG_MC_MD][31:16]);
    md = ext16(cal_regs[REG_MC_MD][15:0]);
    m = it.oversampling_mode;
    r = '0;
    r.divide_error = 1'b1;
    x1 = shr_s(({16'd0, it.raw_temperature} - ac6) * ac5, 15);
    den = x1 + md;
    if (den == 0) return r;
    x2 = div_trunc(mc << 11, den);
    b5 = x1 + x2;
    tmp = shr_s(b5 + 32'd8, 4);
    up = {8'd0, it.raw_pressure} >> (8 - m);
    b6 = b5 - B6_OFFSET;
    sq = shr_s(b6 * b6, 12);
    x1 = shr_s(sq * b2, 11);
    x2 = shr_s(ac2 * b6, 11);
    x3 = x1 + x2;
    b3 = shr_s(((ac1 * 32'd4 + x3) << m) + 32'd2, 2);
    x1 = shr_s(ac3 * b6, 13);
    x2 = shr_s(b1 * sq, 16);
    x3 = shr_s(x1 + x2 + 32'd2, 2);
    b4 = (ac4 * (x3 + B4_OFFSET)) >> 15;
    if (b4 == 0) return r;
    b7 = (up - b3) * (B7_SCALE >> m);
    if (b7 < B7_LIMIT) p = (b7 << 1) / b4;
    else p = (b7 / b4) << 1;
    x1 = shr_s(p, 8);
    x1 = x1 * x1;
    x1 = shr_s(x1 * MG_CONST, 16);
    x2 = shr_s(p * MH_CONST, 16);
    p = p + shr_s(x1 + x2 + MI_CONST, 4);
    r.temperature_tenths = tmp[15:0];
    r.pressure_pa = p;
    r.divide_error = 1'b0;
    return r;
  endfunction

  assign pending_o = expected_q.size();

  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t exp_r;
    int        errs;
    if (!rst_ni) begin
      for (int i = 0; i < NUM_REGS; i++) cal_regs[i] <= '0;
      fail_count_o <= 0;
      result_count_o <= 0;
      div_error_count_o <= 0;
      expected_q.delete();
    end else begin
      errs = 0;
      // Results are checked before the new input is predicted, as they are independent.
      if (out_valid_i && out_ready_i) begin
        result_count_o <= result_count_o + 1;
        if (out_data_i.divide_error) div_error_count_o <= div_error_count_o + 1;
        if (expected_q.size() == 0) begin
          $error("result transfer with nothing expected");
          errs++;
        end else begin
          exp_r = expected_q.pop_front();
          if (out_data_i.temperature_tenths !== exp_r.temperature_tenths) begin
            $error("temperature_tenths expected %0d got %0d",
                   exp_r.temperature_tenths, out_data_i.temperature_tenths);
            errs++;
          end
          if (out_data_i.pressure_pa !== exp_r.pressure_pa) begin
            $error("pressure_pa expected %0d got %0d",
                   exp_r.pressure_pa, out_data_i.pressure_pa);
            errs++;
          end
          if (out_data_i.divide_error !== exp_r.divide_error) begin
            $error("divide_error expected %0d got %0d",
                   exp_r.divide_error, out_data_i.divide_error);
            errs++;
          end
        end
      end
      if (errs != 0) fail_count_o <= fail_count_o + errs;
      if (in_valid_i && in_ready_i) expected_q.push_back(compensate(in_data_i));
      if (psel_i && penable_i && pwrite_i && pready_i && paddr_i[4:2] < NUM_REGS)
        cal_regs[paddr_i[4:2]] <= pwdata_i;
    end
  end
endmodule

FILE: tb/tb_top.sv
// Testbench top: drives items and register writes, and reports the verdict.
`timescale 1ns / 100ps
module tb_top;
  import btpc_pkg::*;

  localparam int PIPE_LAT = 90;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  in_item_t    in_data_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  out_item_t   out_data_o;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  int          fail_count, pending, result_count, div_error_count;
  int          items_sent = 0;
  bit          hold_off = 1'b0;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  baro_temp_pressure_compensation_top uut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_data_i, .out_valid_o, .out_ready_i,
    .out_data_o, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  btpc_scoreboard chk (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_i(in_ready_o), .in_data_i,
    .out_valid_i(out_valid_o), .out_ready_i, .out_data_i(out_data_o),
    .psel_i(psel), .penable_i(penable), .pwrite_i(pwrite), .paddr_i(paddr),
    .pwdata_i(pwdata), .pready_i(pready), .fail_count_o(fail_count),
    .pending_o(pending), .result_count_o(result_count),
    .div_error_count_o(div_error_count)
  );

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // Receiver: random stalls, or a long hold-off when asked.
  always @(negedge clk_i) begin
    int g;
    if (hold_off) begin
      out_ready_i <= 1'b0;
      repeat (200) @(negedge clk_i);
      hold_off = 1'b0;
    end else begin
      g = gap_len();
      if (g == 0 || $urandom_range(0, 3) != 0) out_ready_i <= 1'b1;
      else begin
        out_ready_i <= 1'b0;
        repeat (g - 1) @(negedge clk_i);
      end
    end
  end

  task automatic reg_write(logic [2:0] idx, logic [31:0] val);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= {idx, 2'b00}; pwdata <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    @(negedge clk_i);
  endtask

  // Valid stays up after a transfer when the next item follows with no gap.
  task automatic send_item(in_item_t it, bit no_gap);
    int g;
    g = no_gap ? 0 : gap_len();
    if (g > 0) begin
      in_valid_i <= 1'b0;
      repeat (g) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= it;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
    items_sent++;
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (PIPE_LAT) @(negedge clk_i);
  endtask

  // Calibration sets; set 0 is a typical sensor, sets 1 to 4 are extremes, others are random.
  task automatic load_cal(int set_no);
    logic [31:0] v [8];
    case (set_no)
      0: begin
        v = '{32'd408, 32'hFFFF_FE35, 32'hFFFF_C6D1, 32'd32741, 32'd32757, 32'd23153,
              {16'd6190, 16'd4}, {16'hD4BD, 16'd2868}};
      end
      1: begin
        v = '{32'h7FFF, 32'h7FFF, 32'h7FFF, 32'hFFFF, 32'hFFFF, 32'hFFFF,
              32'h7FFF_7FFF, 32'h7FFF_7FFF};
      end
      2: begin
        v = '{32'h8000, 32'h8000, 32'h8000, 32'h0, 32'h0, 32'h0,
              32'h8000_8000, 32'h8000_8000};
      end
      3: begin
        // Zero MD and AC5 give a zero temperature divisor.
        v = '{32'd408, 32'd0, 32'd0, 32'd32741, 32'd0, 32'd0, 32'd0, {16'd5, 16'd0}};
      end
      4: begin
        // Zero AC5 and MD of minus one give a divisor of minus one with the most
        // negative MC.
        v = '{32'd1, 32'd1, 32'd1, 32'd1, 32'd0, 32'd0, 32'd0, {16'h8000, 16'hFFFF}};
      end
      default: begin
        for (int i = 0; i < 8; i++) v[i] = $urandom();
        if ($urandom_range(0, 1)) v[REG_AC4] = $urandom_range(20000, 40000);
        if ($urandom_range(0, 1)) v[REG_AC5] = $urandom_range(20000, 40000);
      end
    endcase
    for (int i = 0; i < 8; i++) reg_write(3'(i), v[i]);
  endtask

  function automatic in_item_t rand_item();
    in_item_t it;
    it.raw_temperature = 16'($urandom());
    it.raw_pressure = 24'($urandom());
    it.oversampling_mode = 2'($urandom());
    if ($urandom_range(0, 2) != 0) begin
      it.raw_temperature = 16'($urandom_range(20000, 32000));
      it.raw_pressure = 24'($urandom_range(5000000, 12000000));
    end
    return it;
  endfunction

  initial begin
    in_item_t it;
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    // Directed: field extremes and every mode on the typical calibration.
    load_cal(0);
    for (int m = 0; m < 4; m++) begin
      send_item('{16'd27898, 24'd23843 << 8, 2'(m)}, 0);
      send_item('{16'h0000, 24'h000000, 2'(m)}, 0);
      send_item('{16'hFFFF, 24'hFFFFFF, 2'(m)}, 0);
    end
    drain();
    for (int s = 1; s <= 4; s++) begin
      load_cal(s);
      send_item('{16'h0000, 24'h000000, 2'd0}, 0);
      send_item('{16'hFFFF, 24'hFFFFFF, 2'd3}, 0);
      drain();
    end
    // Random phases, each loading a calibration: the typical set every third phase, else a random set.
    for (int ph = 0; ph < 16; ph++) begin
      load_cal(ph % 3 == 0 ? 0 : 5);
      if (ph == 2) hold_off = 1'b1;
      for (int k = 0; k < 100; k++) begin
        it = rand_item();
        send_item(it, ph == 2);
      end
      drain();
    end
    $display("Covered %0d items over several calibrations, %0d results, %0d divide errors.",
             items_sent, result_count, div_error_count);
    if (fail_count == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    #20ms;
    $display("[FAIL] regression broken");
    $finish;
  end
endmodule
